FILE: src/two_layer_sigmoid_mlp_forward_top_assert.svh
// Assertion macros shared by the checkers of the MLP forward block.
// No dependencies; take in with `include.
`ifndef TWO_LAYER_SIGMOID_MLP_FORWARD_TOP_ASSERT_SVH
`define TWO_LAYER_SIGMOID_MLP_FORWARD_TOP_ASSERT_SVH

// same-cycle implication
`define MLPF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MLPF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/mlpf_pkg.sv
// Shared sizes, command codes, control struct and sigmoid table for the MLP block.
// No dependencies.
package mlpf_pkg;

   localparam int INPUTS  = 8;
   localparam int HIDDEN  = 8;
   localparam int OUTPUTS = 4;

   localparam int CMD_W   = 2;
   localparam int INDEX_W = 4;
   localparam int VALUE_W = 16;
   localparam int ACT_W   = 16;

   localparam logic [CMD_W-1:0] CMD_FIRST_WEIGHT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SECOND_WEIGHT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_INPUT         = 2'd2;

   // inner loop runs over inputs then hidden; outer over hidden then outputs
   localparam int J_MAX = (INPUTS > HIDDEN) ? INPUTS : HIDDEN;
   localparam int H_MAX = (HIDDEN > OUTPUTS) ? HIDDEN : OUTPUTS;
   localparam int J_W   = (J_MAX > 1) ? $clog2(J_MAX) : 1;
   localparam int H_W   = (H_MAX > 1) ? $clog2(H_MAX) : 1;

   localparam int FW_DEPTH = HIDDEN * INPUTS;
   localparam int SW_DEPTH = OUTPUTS * HIDDEN;
   localparam int FW_AW    = (FW_DEPTH > 1) ? $clog2(FW_DEPTH) : 1;
   localparam int SW_AW    = (SW_DEPTH > 1) ? $clog2(SW_DEPTH) : 1;
   localparam int IN_AW    = (INPUTS > 1) ? $clog2(INPUTS) : 1;
   localparam int HID_AW   = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;

   // 17b signed activation times 16b signed weight
   localparam int PROD_W = 2 * VALUE_W + 1;
   localparam int ACC_W  = PROD_W + J_W;

   localparam int SIG_SIZE  = 256;
   localparam int SIG_IDX_W = 8;
   localparam int L1_FRAC   = 24;
   localparam int L2_FRAC   = 28;

   localparam logic signed [ACC_W-1:0] L1_LIM = ACC_W'(64'sd1 <<< (L1_FRAC + 3));
   localparam logic signed [ACC_W-1:0] L2_LIM = ACC_W'(64'sd1 <<< (L2_FRAC + 3));

   typedef struct packed {
      logic           idle;
      logic           rd;
      logic           layer;
      logic [J_W-1:0] j;
      logic [H_W-1:0] h;
      logic           acc_clr;
      logic           hid_wr;
      logic           emit_go;
   } ctl_type;

   typedef logic [ACT_W-1:0] sig_table_type [SIG_SIZE];

   // restoring division, elaboration only
   function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], n[i]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic sig_table_type build_sig_table();
      sig_table_type t;
      logic [63:0]   pos;
      logic [63:0]   neg;
      logic [63:0]   term;
      logic [63:0]   e;
      logic [63:0]   p;
      logic [63:0]   d;
      logic [63:0]   num;
      logic [63:0]   r;
      logic [127:0]  prod;
      logic [63:0]   pw [129];
      int            m;
      pos  = '0;
      neg  = '0;
      term = 64'd1 << 32;
      // e^(-1/16) in Q32, truncated Taylor terms
      for (int n = 0; n < 12; n++) begin
         if (n > 0) term = udiv64(term, 64'(16 * n));
         if ((n & 1) != 0) neg = neg + term;
         else pos = pos + term;
      end
      e = pos - neg;
      p = 64'd1 << 32;
      pw[0] = p;
      for (int k = 1; k <= 128; k++) begin
         prod  = {64'd0, p} * {64'd0, e} + (128'd1 << 31);
         p     = prod[95:32];
         pw[k] = p;
      end
      for (int k = 0; k < SIG_SIZE; k++) begin
         if (k >= 128) begin
            m   = k - 128;
            d   = (64'd1 << 32) + pw[m];
            num = 64'd1 << 48;
         end else begin
            m   = 128 - k;
            d   = (64'd1 << 32) + pw[m];
            num = pw[m] << 16;
         end
         r = udiv64(num + (d >> 1), d);
         t[k] = (r > 64'd65535) ? 16'hFFFF : r[15:0];
      end
      return t;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

   // clamp to [-8, 8) in the layer's format and take the top 8 bits
   function automatic logic [SIG_IDX_W-1:0] sig_index(logic signed [ACC_W-1:0] sum,
                                                      logic layer2);
      logic signed [ACC_W-1:0] lim;
      logic [ACC_W-1:0]        biased;
      logic [SIG_IDX_W-1:0]    idx;
      lim    = layer2 ? L2_LIM : L1_LIM;
      biased = sum + lim;
      if (sum < -lim) idx = '0;
      else if (sum >= lim) idx = '1;
      else if (layer2) idx = biased[L2_FRAC+3:L2_FRAC-4];
      else idx = biased[L1_FRAC+3:L1_FRAC-4];
      return idx;
   endfunction

endpackage

FILE: src/mlpf_if.sv
// Request and response channel interfaces for the MLP block.
// Depends on mlpf_pkg.
interface mlpf_req_if;
   import mlpf_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          cmd;
   logic [INDEX_W-1:0]        source_index;
   logic [INDEX_W-1:0]        dest_index;
   logic signed [VALUE_W-1:0] value;
   logic                      start_req;
   modport source(output valid, cmd, source_index, dest_index, value, start_req,
                  input ready);
   modport sink(input valid, cmd, source_index, dest_index, value, start_req,
                output ready);
endinterface

interface mlpf_rsp_if;
   import mlpf_pkg::*;
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] out_neuron;
   logic [ACT_W-1:0]   activation;
   logic               last;
   modport source(output valid, out_neuron, activation, last, input ready);
   modport sink(input valid, out_neuron, activation, last, output ready);
endinterface

FILE: src/mlpf_ram.sv
// Simple dual-port RAM: one write port, one registered read port, no reset.
// No dependencies.
module mlpf_ram #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/mlpf_sequencer.sv
// Microcode sequencer: step counter, control ROM, loop counters and branch logic.
// Depends on mlpf_pkg.
module mlpf_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              start_seen,
   input  logic              out_busy,
   output mlpf_pkg::ctl_type ctl
);
   import mlpf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_L1_MAC, ST_L1_D1, ST_L1_D2, ST_L1_FIN,
      ST_L2_MAC, ST_L2_D1, ST_L2_D2, ST_L2_FIN, ST_DONE
   } step_type;

   typedef enum logic [2:0] {
      COND_NEXT, COND_ALWAYS, COND_WAIT_START, COND_J_MORE, COND_H_MORE
   } cond_type;

   typedef struct packed {
      logic     idle;
      logic     clr;
      logic     rd;
      logic     layer;
      logic     hid_wr;
      logic     emit;
      cond_type cond;
      step_type target;
   } uword_type;

   localparam logic [J_W-1:0] J1_LAST = J_W'(INPUTS - 1);
   localparam logic [J_W-1:0] J2_LAST = J_W'(HIDDEN - 1);
   localparam logic [H_W-1:0] H1_LAST = H_W'(HIDDEN - 1);
   localparam logic [H_W-1:0] H2_LAST = H_W'(OUTPUTS - 1);

   // control store; branch taken goes to target, else to the next step
   function automatic uword_type ucode(step_type s);
      uword_type uw;
      uw        = '0;
      uw.cond   = COND_NEXT;
      uw.target = ST_IDLE;
      case (s)
         ST_IDLE: begin
            uw.idle   = 1'b1;
            uw.clr    = 1'b1;
            uw.cond   = COND_WAIT_START;
            uw.target = ST_IDLE;
         end
         ST_L1_MAC: begin
            uw.rd     = 1'b1;
            uw.cond   = COND_J_MORE;
            uw.target = ST_L1_MAC;
         end
         ST_L1_D1, ST_L1_D2: uw.layer = 1'b0;
         ST_L1_FIN: begin
            uw.hid_wr = 1'b1;
            uw.cond   = COND_H_MORE;
            uw.target = ST_L1_MAC;
         end
         ST_L2_MAC: begin
            uw.layer  = 1'b1;
            uw.rd     = 1'b1;
            uw.cond   = COND_J_MORE;
            uw.target = ST_L2_MAC;
         end
         ST_L2_D1, ST_L2_D2: uw.layer = 1'b1;
         ST_L2_FIN: begin
            uw.layer  = 1'b1;
            uw.emit   = 1'b1;
            uw.cond   = COND_H_MORE;
            uw.target = ST_L2_MAC;
         end
         ST_DONE: begin
            uw.cond   = COND_ALWAYS;
            uw.target = ST_IDLE;
         end
         default: begin
            uw.cond   = COND_ALWAYS;
            uw.target = ST_IDLE;
         end
      endcase
      return uw;
   endfunction

   step_type       step_ff, step_in;
   logic [J_W-1:0] j_ff, j_in;
   logic [H_W-1:0] h_ff, h_in;
   uword_type      uw;
   logic [J_W-1:0] j_last;
   logic [H_W-1:0] h_last;
   logic           stall;
   logic           taken;

   always_comb begin
      uw     = ucode(step_ff);
      j_last = uw.layer ? J2_LAST : J1_LAST;
      h_last = uw.layer ? H2_LAST : H1_LAST;
      // result register still full: hold the emit step
      stall  = uw.emit && out_busy;

      case (uw.cond)
         COND_NEXT:       taken = 1'b0;
         COND_ALWAYS:     taken = 1'b1;
         COND_WAIT_START: taken = !start_seen;
         COND_J_MORE:     taken = (j_ff != j_last);
         COND_H_MORE:     taken = (h_ff != h_last);
         default:         taken = 1'b0;
      endcase

      if (stall) step_in = step_ff;
      else if (taken) step_in = uw.target;
      else step_in = step_type'(step_ff + 1'b1);

      j_in = j_ff;
      if (uw.clr) j_in = '0;
      else if (uw.rd) j_in = (j_ff == j_last) ? '0 : j_ff + 1'b1;

      h_in = h_ff;
      if (uw.clr) h_in = '0;
      else if ((uw.hid_wr || uw.emit) && !stall) h_in = (h_ff == h_last) ? '0 : h_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
         j_ff    <= '0;
         h_ff    <= '0;
      end else begin
         step_ff <= step_in;
         j_ff    <= j_in;
         h_ff    <= h_in;
      end
   end

   always_comb begin
      ctl.idle    = uw.idle;
      ctl.rd      = uw.rd;
      ctl.layer   = uw.layer;
      ctl.j       = j_ff;
      ctl.h       = h_ff;
      ctl.acc_clr = uw.clr || uw.hid_wr || (uw.emit && !stall);
      ctl.hid_wr  = uw.hid_wr;
      ctl.emit_go = uw.emit && !stall;
   end

endmodule

FILE: src/mlpf_datapath.sv
// Datapath: weight/input/hidden stores, shared multiply-accumulate, clamp and sigmoid.
// Depends on mlpf_pkg and mlpf_ram.
module mlpf_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  mlpf_pkg::ctl_type                  ctl,
   input  logic                               wr_go,
   input  logic [mlpf_pkg::CMD_W-1:0]         cmd,
   input  logic [mlpf_pkg::INDEX_W-1:0]       source_index,
   input  logic [mlpf_pkg::INDEX_W-1:0]       dest_index,
   input  logic signed [mlpf_pkg::VALUE_W-1:0] value,
   output logic [mlpf_pkg::ACT_W-1:0]         activation
);
   import mlpf_pkg::*;

   logic                fw_we, sw_we, in_we;
   logic [FW_AW-1:0]    fw_waddr, fw_raddr;
   logic [SW_AW-1:0]    sw_waddr, sw_raddr;
   logic [IN_AW-1:0]    in_waddr, in_raddr;
   logic [HID_AW-1:0]   hid_waddr, hid_raddr;
   logic [VALUE_W-1:0]  fw_rdata, sw_rdata, in_rdata;
   logic [ACT_W-1:0]    hid_rdata;

   // written-since-reset bits; an unwritten entry reads as zero
   logic [FW_DEPTH-1:0] fw_vld_ff;
   logic [SW_DEPTH-1:0] sw_vld_ff;
   logic [INPUTS-1:0]   in_vld_ff;
   logic                fw_vld_rd_ff, sw_vld_rd_ff, in_vld_rd_ff;

   logic                rd_v_ff, layer2_ff, prod_v_ff;
   logic signed [VALUE_W:0]   op_a;
   logic signed [VALUE_W-1:0] op_w;
   logic [VALUE_W-1:0]        fw_val, sw_val, in_val;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;

   always_comb begin
      fw_we = wr_go && (cmd == CMD_FIRST_WEIGHT) &&
              (32'(source_index) < INPUTS) && (32'(dest_index) < HIDDEN);
      sw_we = wr_go && (cmd == CMD_SECOND_WEIGHT) &&
              (32'(source_index) < HIDDEN) && (32'(dest_index) < OUTPUTS);
      in_we = wr_go && (cmd == CMD_INPUT) && (32'(source_index) < INPUTS);

      fw_waddr = FW_AW'(32'(dest_index) * INPUTS + 32'(source_index));
      sw_waddr = SW_AW'(32'(dest_index) * HIDDEN + 32'(source_index));
      in_waddr = IN_AW'(source_index);

      // park the unused layer's ports at address zero
      fw_raddr  = ctl.layer ? '0 : FW_AW'(32'(ctl.h) * INPUTS + 32'(ctl.j));
      sw_raddr  = ctl.layer ? SW_AW'(32'(ctl.h) * HIDDEN + 32'(ctl.j)) : '0;
      in_raddr  = ctl.layer ? '0 : ctl.j[IN_AW-1:0];
      hid_raddr = ctl.layer ? ctl.j[HID_AW-1:0] : '0;
      hid_waddr = ctl.h[HID_AW-1:0];
   end

   mlpf_ram #(.DEPTH(FW_DEPTH), .WIDTH(VALUE_W)) u_fw_ram (
      .clock(clock), .we(fw_we), .waddr(fw_waddr), .wdata(value),
      .raddr(fw_raddr), .rdata(fw_rdata)
   );

   mlpf_ram #(.DEPTH(SW_DEPTH), .WIDTH(VALUE_W)) u_sw_ram (
      .clock(clock), .we(sw_we), .waddr(sw_waddr), .wdata(value),
      .raddr(sw_raddr), .rdata(sw_rdata)
   );

   mlpf_ram #(.DEPTH(INPUTS), .WIDTH(VALUE_W)) u_in_ram (
      .clock(clock), .we(in_we), .waddr(in_waddr), .wdata(value),
      .raddr(in_raddr), .rdata(in_rdata)
   );

   mlpf_ram #(.DEPTH(HIDDEN), .WIDTH(ACT_W)) u_hid_ram (
      .clock(clock), .we(ctl.hid_wr), .waddr(hid_waddr), .wdata(activation),
      .raddr(hid_raddr), .rdata(hid_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_vld_ff <= '0;
         sw_vld_ff <= '0;
         in_vld_ff <= '0;
      end else begin
         if (fw_we) fw_vld_ff[fw_waddr] <= 1'b1;
         if (sw_we) sw_vld_ff[sw_waddr] <= 1'b1;
         if (in_we) in_vld_ff[in_waddr] <= 1'b1;
      end
      fw_vld_rd_ff <= fw_vld_ff[fw_raddr];
      sw_vld_rd_ff <= sw_vld_ff[sw_raddr];
      in_vld_rd_ff <= in_vld_ff[in_raddr];
   end

   always_comb begin
      fw_val = fw_vld_rd_ff ? fw_rdata : '0;
      sw_val = sw_vld_rd_ff ? sw_rdata : '0;
      in_val = in_vld_rd_ff ? in_rdata : '0;
      // hidden activations are unsigned Q0.16, inputs signed Q4.12
      op_a = layer2_ff ? $signed({1'b0, hid_rdata}) : $signed({in_val[VALUE_W-1], in_val});
      op_w = layer2_ff ? $signed(sw_val) : $signed(fw_val);
      acc_in = acc_ff;
      if (ctl.acc_clr) acc_in = '0;
      else if (prod_v_ff) acc_in = acc_ff + prod_ff;
   end

   // read -> multiply -> accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff   <= 1'b0;
         prod_v_ff <= 1'b0;
         acc_ff    <= '0;
      end else begin
         rd_v_ff   <= ctl.rd;
         prod_v_ff <= rd_v_ff;
         acc_ff    <= acc_in;
      end
      layer2_ff <= ctl.layer;
      prod_ff   <= op_a * op_w;
   end

   assign activation = SIG_TABLE[sig_index(acc_ff, ctl.layer)];

endmodule

FILE: src/two_layer_sigmoid_mlp_forward_top.sv
// Two-layer sigmoid MLP forward pass. A request word writes one first-layer
// weight, one second-layer weight or one input; an input write with start_req
// set runs the pass and returns OUTPUTS response words, the final one with last.
// A start word holds the request side for the whole pass, which runs longer
// if the response side stalls; each neuron is one pass of the single shared
// multiplier over its weights plus the read, multiply and accumulate
// pipeline, stepped by the microcode sequencer.
// Depends on mlpf_pkg, mlpf_if, mlpf_sequencer, mlpf_datapath.
module two_layer_sigmoid_mlp_forward_top (
   input logic              clock,
   input logic              reset,
   mlpf_req_if.sink         req_ch,
   mlpf_rsp_if.source       rsp_ch
);
   import mlpf_pkg::*;

   ctl_type            ctl;
   logic               req_go;
   logic               start_seen;
   logic               out_busy;
   logic [ACT_W-1:0]   act;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic [ACT_W-1:0]   rsp_act_ff;
   logic               rsp_last_ff;

   assign req_ch.ready = ctl.idle && !reset;
   assign req_go       = req_ch.valid && req_ch.ready;
   assign start_seen   = req_go && (req_ch.cmd == CMD_INPUT) && req_ch.start_req;
   assign out_busy     = rsp_valid_ff && !rsp_ch.ready;

   mlpf_sequencer u_seq (
      .clock(clock),
      .reset(reset),
      .start_seen(start_seen),
      .out_busy(out_busy),
      .ctl(ctl)
   );

   mlpf_datapath u_dp (
      .clock(clock),
      .reset(reset),
      .ctl(ctl),
      .wr_go(req_go),
      .cmd(req_ch.cmd),
      .source_index(req_ch.source_index),
      .dest_index(req_ch.dest_index),
      .value(req_ch.value),
      .activation(act)
   );

   assign rsp_valid_in = ctl.emit_go || out_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (ctl.emit_go) begin
         rsp_index_ff <= INDEX_W'(ctl.h);
         rsp_act_ff   <= act;
         rsp_last_ff  <= (ctl.h == H_W'(OUTPUTS - 1));
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_neuron = rsp_index_ff;
   assign rsp_ch.activation = rsp_act_ff;
   assign rsp_ch.last       = rsp_last_ff;

endmodule

FILE: src/two_layer_sigmoid_mlp_forward_checker.sv
// Port-level checker for the MLP block, bound to the top level.
// Depends on mlpf_pkg and two_layer_sigmoid_mlp_forward_top_assert.svh.
`include "two_layer_sigmoid_mlp_forward_top_assert.svh"

module two_layer_sigmoid_mlp_forward_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [mlpf_pkg::CMD_W-1:0]         req_cmd,
   input logic                               req_start_req,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [mlpf_pkg::INDEX_W-1:0]       rsp_out_neuron,
   input logic [mlpf_pkg::ACT_W-1:0]         rsp_activation,
   input logic                               rsp_last
);
   import mlpf_pkg::*;

   `MLPF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid,
      "response word dropped while stalled")

   `MLPF_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready,
      $stable(rsp_activation) && $stable(rsp_out_neuron) && $stable(rsp_last),
      "response word changed while stalled")

   `MLPF_ASSERT_NXT(a_start_busy, clock, reset,
      req_valid && req_ready && (req_cmd == CMD_INPUT) && req_start_req, !req_ready,
      "request taken right after a start word")

   `MLPF_ASSERT_NXT(a_pass_busy, clock, reset, rsp_valid && rsp_ready && !rsp_last,
      !req_ready, "request side open before the pass ended")

   `MLPF_ASSERT_IMP(a_last_index, clock, reset, rsp_valid && rsp_last,
      rsp_out_neuron == INDEX_W'(OUTPUTS - 1), "last flag on wrong output neuron")

endmodule

bind two_layer_sigmoid_mlp_forward_top two_layer_sigmoid_mlp_forward_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_ch.valid),
   .req_ready(req_ch.ready),
   .req_cmd(req_ch.cmd),
   .req_start_req(req_ch.start_req),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_out_neuron(rsp_ch.out_neuron),
   .rsp_activation(rsp_ch.activation),
   .rsp_last(rsp_ch.last)
);
